// ----- hw/rtl/bchd_pkg.sv -----
// Shared types, constants and helpers for the button click/hold detector.
package bchd_pkg;

    localparam int TICK_W     = 8;
    localparam int TIME_W     = 16;
    localparam int CLICK_W    = 8;
    localparam int MODE_W     = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Mode codes as seen on the key_mode port
    localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DITHER    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PRE_CLICK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PRESS     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HOLD      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MULTI     = 3'd5;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESS_THR   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_THR    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL    = 2'd3;

    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 8'd10;
    localparam logic [TIME_W-1:0] PRESS_THR_RST   = 16'd20;
    localparam logic [TIME_W-1:0] HOLD_THR_RST    = 16'd1000;
    localparam logic [TIME_W-1:0] INTERVAL_RST    = 16'd300;

    typedef struct packed {
        logic [TICK_W-1:0] tick_period;
        logic [TIME_W-1:0] press_limit;
        logic [TIME_W-1:0] hold_limit;
        logic [TIME_W-1:0] gap_limit;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]  key_mode;
        logic               press_event;
        logic               hold_event;
        logic               multi_click_event;
        logic [CLICK_W-1:0] clicks;
    } result_t;

    function automatic logic [TIME_W-1:0] sat_add_time(
        input logic [TIME_W-1:0] a,
        input logic [TICK_W-1:0] b
    );
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {{(TIME_W - TICK_W + 1){1'b0}}, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    function automatic logic [CLICK_W-1:0] sat_inc_click(input logic [CLICK_W-1:0] a);
        return (a == {CLICK_W{1'b1}}) ? a : a + {{(CLICK_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// ----- hw/rtl/button_click_hold_detector.sv -----
// Top level of the single-key click, hold and multi-click detector.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | input     | in_valid / in_ready  | key_pressed
//   out     | output    | out_valid / out_ready| key_mode, press_event, hold_event,
//           |           |                      | multi_click_event, clicks
//   apb     | input     | psel/penable/pready  | paddr, pwdata, pwrite -> prdata
//
// One item per cycle sustained while out_ready stays high; a result shows on the
// outputs once its item has passed the input register and then the mode update
// into the result register, and is taken when out_ready is high.
// The mode update of the state machine sets that rate.
// Reset (rst_n low) clears both stages, the mode machine, all counters, and
// loads the register defaults (tick 10, press 20, hold 1000, interval 300).
// A stalled result holds in the result register; the input register takes an
// item while it is empty or passing its item on, and holds its item until the
// result register frees.
module button_click_hold_detector
    import bchd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  key_pressed,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MODE_W-1:0]     key_mode,
    output logic                  press_event,
    output logic                  hold_event,
    output logic                  multi_click_event,
    output logic [CLICK_W-1:0]    clicks,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    result_t result;

    logic in_valid_reg, in_valid_next;
    logic key_reg;
    logic out_valid_reg, out_valid_next;
    logic out_open;
    logic step;

    // The result register can load when empty or being drained this cycle
    assign out_open = !out_valid_reg || out_ready;
    // Move the held item through the mode update into the result register
    assign step     = in_valid_reg && out_open;
    assign in_ready = !in_valid_reg || out_open;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the key level of each accepted item; no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            key_reg <= key_pressed;
    end

    bchd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bchd_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .key_down (key_reg),
        .cfg      (cfg),
        .result   (result)
    );

    assign out_valid         = out_valid_reg;
    assign key_mode          = result.key_mode;
    assign press_event       = result.press_event;
    assign hold_event        = result.hold_event;
    assign multi_click_event = result.multi_click_event;
    assign clicks            = result.clicks;

endmodule

// ----- hw/rtl/bchd_cfg.sv -----
// APB register file holding tick period and the three time thresholds.
module bchd_cfg
    import bchd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period <= TICK_PERIOD_RST;
            cfg_reg.press_limit <= PRESS_THR_RST;
            cfg_reg.hold_limit  <= HOLD_THR_RST;
            cfg_reg.gap_limit   <= INTERVAL_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TICK_PERIOD: cfg_reg.tick_period <= pwdata[TICK_W-1:0];
                REG_PRESS_THR:   cfg_reg.press_limit <= pwdata[TIME_W-1:0];
                REG_HOLD_THR:    cfg_reg.hold_limit  <= pwdata[TIME_W-1:0];
                REG_INTERVAL:    cfg_reg.gap_limit   <= pwdata[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_TICK_PERIOD: prdata[TICK_W-1:0] = cfg_reg.tick_period;
            REG_PRESS_THR:   prdata[TIME_W-1:0] = cfg_reg.press_limit;
            REG_HOLD_THR:    prdata[TIME_W-1:0] = cfg_reg.hold_limit;
            REG_INTERVAL:    prdata[TIME_W-1:0] = cfg_reg.gap_limit;
            default:         prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/bchd_fsm.sv -----
// Mode machine, time counters, click count and the registered result.
module bchd_fsm
    import bchd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    key_down,
    input  cfg_t    cfg,
    output result_t result
);

    typedef enum logic [MODE_W-1:0] {
        ST_RELEASE   = MODE_RELEASE,
        ST_DITHER    = MODE_DITHER,
        ST_PRE_CLICK = MODE_PRE_CLICK,
        ST_PRESS     = MODE_PRESS,
        ST_HOLD      = MODE_HOLD,
        ST_MULTI     = MODE_MULTI
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [TIME_W-1:0]  pressed_reg, pressed_next;
    logic [TIME_W-1:0]  released_reg, released_next;
    logic [CLICK_W-1:0] clicks_reg, clicks_next;
    result_t            result_reg, result_next;
    logic [TIME_W-1:0]  pt, rt;

    assign result = result_reg;

    always_comb
    begin
        // advance the counter that matches the key level
        pt = key_down ? sat_add_time(pressed_reg, cfg.tick_period) : pressed_reg;
        rt = key_down ? released_reg : sat_add_time(released_reg, cfg.tick_period);

        mode_next     = mode_reg;
        pressed_next  = pt;
        released_next = rt;
        clicks_next   = clicks_reg;

        unique case (mode_reg)
            ST_RELEASE:
            begin
                clicks_next = '0;
                if (key_down)
                    mode_next = ST_DITHER;
            end
            ST_DITHER:
            begin
                if (pt > cfg.hold_limit)
                    mode_next = ST_HOLD;
                if (!key_down)
                begin
                    if (pt > cfg.press_limit && pt < cfg.hold_limit)
                    begin
                        mode_next     = ST_PRE_CLICK;
                        clicks_next   = sat_inc_click(clicks_reg);
                        released_next = '0;
                    end
                    else
                        mode_next = ST_RELEASE;
                    pressed_next = '0;
                end
            end
            ST_PRE_CLICK:
            begin
                if (rt < cfg.gap_limit)
                begin
                    if (key_down)
                    begin
                        mode_next     = ST_MULTI;
                        clicks_next   = sat_inc_click(clicks_reg);
                        released_next = '0;
                    end
                end
                else
                    mode_next = ST_PRESS;
            end
            ST_PRESS, ST_HOLD:
            begin
                if (!key_down)
                begin
                    mode_next    = ST_RELEASE;
                    pressed_next = '0;
                end
            end
            ST_MULTI:
            begin
                if (rt > cfg.gap_limit)
                begin
                    mode_next     = ST_RELEASE;
                    pressed_next  = '0;
                    released_next = '0;
                    clicks_next   = '0;
                end
                else if (key_down)
                    mode_next = ST_DITHER;
            end
            default: ;
        endcase

        result_next.key_mode          = mode_next;
        result_next.press_event       = (mode_reg == ST_PRESS);
        result_next.hold_event        = (mode_reg == ST_HOLD);
        result_next.multi_click_event = (mode_reg == ST_MULTI);
        result_next.clicks            = clicks_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ST_RELEASE;
            pressed_reg  <= '0;
            released_reg <= '0;
            clicks_reg   <= '0;
            result_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            clicks_reg   <= clicks_next;
            result_reg   <= result_next;
        end
    end

endmodule

// ----- hw/rtl/bchd_checker.sv -----
// Port-level assertions for the detector, bound onto the top level.
module bchd_checker
    import bchd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [MODE_W-1:0]  key_mode,
    input logic               press_event,
    input logic               hold_event,
    input logic               multi_click_event,
    input logic [CLICK_W-1:0] clicks
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_mode) && $stable(clicks))
        else $error("stalled result changed");

    // The start mode is one state, so at most one event fires
    a_event_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({press_event, hold_event, multi_click_event}))
        else $error("more than one event in a result");

    // Press only stays or drops to release
    a_press_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_event |-> key_mode == MODE_PRESS || key_mode == MODE_RELEASE)
        else $error("bad exit from press");

    // Hold only stays or drops to release
    a_hold_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold_event |-> key_mode == MODE_HOLD || key_mode == MODE_RELEASE)
        else $error("bad exit from hold");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .key_mode          (key_mode),
    .press_event       (press_event),
    .hold_event        (hold_event),
    .multi_click_event (multi_click_event),
    .clicks            (clicks)
);
